// ===== rtl/core/b85dec_pkg.sv =====
package b85dec_pkg;

   // First and last printable code of the alphabet
   localparam logic [7:0] CharFirst = 8'd33;
   localparam logic [7:0] CharLast  = 8'd126;
   localparam int unsigned TableDepth = 94;

   // Digit code for a character outside the alphabet
   localparam logic [6:0] DigitBad = 7'd85;

   // Digits per group and bytes per group
   localparam logic [2:0] GroupDigits = 3'd5;
   localparam logic [2:0] GroupBytes  = 3'd4;

   // Transaction queue between front and back
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

   // Character to digit value, ordered from code 33 upwards
   localparam logic [6:0] DigitTable [TableDepth] = '{
      7'd62, 7'd85, 7'd63, 7'd64, 7'd65, 7'd66, 7'd85, 7'd67, 7'd68, 7'd69,
      7'd70, 7'd85, 7'd71, 7'd85, 7'd85, 7'd0,  7'd1,  7'd2,  7'd3,  7'd4,
      7'd5,  7'd6,  7'd7,  7'd8,  7'd9,  7'd85, 7'd72, 7'd73, 7'd74, 7'd75,
      7'd76, 7'd77, 7'd10, 7'd11, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17,
      7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27,
      7'd28, 7'd29, 7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd85, 7'd85,
      7'd85, 7'd78, 7'd79, 7'd80, 7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41,
      7'd42, 7'd43, 7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51,
      7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57, 7'd58, 7'd59, 7'd60, 7'd61,
      7'd81, 7'd82, 7'd83, 7'd84
   };

   // One queued transaction: a group value with its byte count and padding
   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  nbytes;
      logic [2:0]  pad;
      logic        err;
      logic        eos;
   } entry_type;

   // Queue status seen by the back end
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [6:0] digit_of(input logic [7:0] c);
      logic [6:0] d;
      d = DigitBad;
      if (c >= CharFirst && c <= CharLast) begin
         d = DigitTable[7'(c - CharFirst)];
      end
      return d;
   endfunction

   // 85 raised to the number of pad digits
   function automatic logic [25:0] pad_scale(input logic [2:0] pad);
      logic [25:0] s;
      case (pad)
         3'd1:    s = 26'd85;
         3'd2:    s = 26'd7225;
         3'd3:    s = 26'd614125;
         3'd4:    s = 26'd52200625;
         default: s = 26'd1;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/b85dec_front.sv =====
module b85dec_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] char_code
   input  logic                   req_tlast,   // end_of_stream
   input  b85dec_pkg::queue_status_type q_status,
   output logic                   push,
   output b85dec_pkg::entry_type  push_entry
);

   logic [31:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        failed_ff, failed_in;

   logic        accept;
   logic [6:0]  digit;
   logic [31:0] acc_next;
   logic [2:0]  cnt_inc;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign digit      = b85dec_pkg::digit_of(req_tdata);
   assign acc_next   = acc_ff * 32'd85 + {25'd0, digit};
   assign cnt_inc    = cnt_ff + 3'd1;

   // Classify the character and update the partial group
   always_comb begin
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      failed_in  = failed_ff;
      push       = 1'b0;
      push_entry = '{value: acc_next, nbytes: 3'd0, pad: 3'd0, err: 1'b0, eos: req_tlast};
      if (accept) begin
         if (failed_ff) begin
            if (req_tlast) begin
               failed_in = 1'b0;
            end
         end else if (digit == b85dec_pkg::DigitBad) begin
            push              = 1'b1;
            push_entry.value  = 32'd0;
            push_entry.nbytes = 3'd1;
            push_entry.err    = 1'b1;
            acc_in            = 32'd0;
            cnt_in            = 3'd0;
            failed_in         = !req_tlast;
         end else if (cnt_inc == b85dec_pkg::GroupDigits) begin
            push              = 1'b1;
            push_entry.nbytes = b85dec_pkg::GroupBytes;
            acc_in            = 32'd0;
            cnt_in            = 3'd0;
         end else if (req_tlast) begin
            // partial group: padded in the back end, a lone digit gives nothing
            push              = (cnt_inc > 3'd1);
            push_entry.nbytes = cnt_inc - 3'd1;
            push_entry.pad    = b85dec_pkg::GroupDigits - cnt_inc;
            acc_in            = 32'd0;
            cnt_in            = 3'd0;
         end else begin
            acc_in = acc_next;
            cnt_in = cnt_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= 32'd0;
         cnt_ff    <= 3'd0;
         failed_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         failed_ff <= failed_in;
      end
   end

endmodule

// ===== rtl/core/b85dec_queue.sv =====
module b85dec_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  b85dec_pkg::entry_type  push_entry,
   input  logic                   pop,
   output b85dec_pkg::entry_type  head,
   output b85dec_pkg::queue_status_type status
);

   localparam int unsigned PtrW = b85dec_pkg::QueuePtrW;

   b85dec_pkg::entry_type slot_ff [b85dec_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   count_ff, count_in;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (PtrW+1)'(b85dec_pkg::QueueDepth));

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/b85dec_back.sv =====
module b85dec_back (
   input  logic                   clock,
   input  logic                   reset,
   input  b85dec_pkg::entry_type  head,
   input  b85dec_pkg::queue_status_type q_status,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] data_byte
   output logic [2:0]             rsp_tuser,   // [0] byte_valid, [1] error, [2] stream_end
   output logic                   rsp_tlast    // run_last
);

   logic [31:0] word_ff, word_in;
   logic [2:0]  left_ff, left_in;
   logic        err_ff, err_in;
   logic        eos_ff, eos_in;

   logic        taken;
   logic [31:0] padded;
   logic [31:0] scaled;

   assign taken = rsp_tvalid && rsp_tready;
   assign pop   = !q_status.empty && ((left_ff == 3'd0) || (taken && left_ff == 3'd1));

   // Pad a partial group: (v + 1) * 85^m - 1 equals m trailing digits of 84
   assign scaled = (head.value + 32'd1) * {6'd0, b85dec_pkg::pad_scale(head.pad)};
   assign padded = (head.pad == 3'd0) ? head.value : scaled - 32'd1;

   // Byte serialiser, most significant byte first
   always_comb begin
      word_in = word_ff;
      left_in = left_ff;
      err_in  = err_ff;
      eos_in  = eos_ff;
      if (pop) begin
         word_in = padded;
         left_in = head.nbytes;
         err_in  = head.err;
         eos_in  = head.eos;
      end else if (taken) begin
         word_in = {word_ff[23:0], 8'd0};
         left_in = left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 3'd0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      err_ff  <= err_in;
      eos_ff  <= eos_in;
   end

   assign rsp_tvalid = (left_ff != 3'd0);
   assign rsp_tdata  = word_ff[31:24];
   assign rsp_tlast  = (left_ff == 3'd1);
   assign rsp_tuser  = {eos_ff && rsp_tlast, err_ff, !err_ff};

endmodule

// ===== rtl/core/base85_decoder.sv =====
// Streaming base85 decoder, RFC 1924 / Python b85 alphabet.
// Request channel: one character per transaction, code in req_tdata,
// req_tlast marks the last character of a stream.
// Response channel: one byte per transaction in rsp_tdata; rsp_tuser carries
// byte_valid, error and stream_end; rsp_tlast marks the last response caused
// by one character. Five characters give four bytes; a final group of k
// characters gives k-1 bytes. An invalid character gives one error response
// and the rest of that stream is dropped silently.
// Throughput: one character per cycle is accepted while the four-entry
// transaction queue between the classifier and the byte serialiser has room;
// the serialiser sends one byte per cycle while rsp_tready is high. A group
// that a character completes is written to a queue slot and then loaded
// into the serialiser word register, from which its first byte appears on
// the response port.
// The padding multiply sits in the queue-to-serialiser path.
// Reset (synchronous, active high) empties the queue, clears the partial
// group and the failure flag. When the receiver holds rsp_tready low, the
// current byte is held, the queue fills, and req_tready drops once it is full.
module base85_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // end_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [2:0] rsp_tuser,   // [0] byte_valid, [1] error, [2] stream_end
   output logic       rsp_tlast    // run_last
);

   logic                         q_push;
   logic                         q_pop;
   b85dec_pkg::entry_type        q_push_entry;
   b85dec_pkg::entry_type        q_head;
   b85dec_pkg::queue_status_type q_status;

   // Classifier and group accumulator
   b85dec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (q_push),
      .push_entry (q_push_entry)
   );

   // Transaction queue
   b85dec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // Padding and byte serialiser
   b85dec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .q_status   (q_status),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // An error response stands alone and carries no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && !rsp_tuser[0] && rsp_tdata == 8'd0)
      else $error("error response not a lone empty transaction");

   // Stream end only on the last response of a character
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tlast)
      else $error("stream_end outside last response");

   // Nothing pending and room to accept on the first cycle out of reset
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid && req_tready)
      else $error("state not cleared by reset");

   // The serialiser only takes from a non-empty queue
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");
`endif

endmodule
